// ===== rtl/core/trqm_pkg.sv =====
`timescale 1ns / 1ps

package trqm_pkg;

    // Default sizing of the task table and the id counter.
    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    // Fixed field widths of the streams.
    localparam int ACTION_W  = 3;
    localparam int TASK_ID_W = 16;
    localparam int HANDLE_W  = 32;
    localparam int STATUS_W  = 3;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 56;

    // Operation codes.
    localparam logic [ACTION_W-1:0] ACT_ADD      = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DISPATCH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_FINISH   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_NULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STS_RUNNING   = 3'd5;

    // Slot life-cycle codes.
    typedef enum logic [1:0] {
        SLOT_FREE    = 2'd0,
        SLOT_STOPPED = 2'd1,
        SLOT_SCHED   = 2'd2,
        SLOT_RUN     = 2'd3
    } slot_state_t;

    // Which slots a table walk accepts.
    typedef enum logic [1:0] {
        MATCH_FREE,
        MATCH_STOPPED,
        MATCH_LIVE
    } match_mode_t;

endpackage

// ===== rtl/core/trqm_ram.sv =====
`timescale 1ns / 1ps

module trqm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/task_run_queue_manager_core.sv =====
`timescale 1ns / 1ps
// Add, schedule, query and remove walk the task table one slot a cycle through the id
// memory; a remove of a queued task that is not at the head then follows the queue links.
// Dispatch reads the queue head, while finish, an add with a null handle and an unknown
// action go straight to the result.
// One transfer is worked on at a time; a result waits in the output register.
// Reset (rst_n low, asynchronous) frees every slot, empties the queue and clears the id
// counter; the memories need no clearing.
module task_run_queue_manager_core #(
    parameter int SLOTS   = trqm_pkg::SLOTS_DEF,
    parameter int ID_BITS = trqm_pkg::ID_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // action[2:0], task_id[18:3], task_handle[50:19], zeros above
    input  logic [trqm_pkg::IN_DATA_W-1:0]  s_tdata,
    // task_kind[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], result_id[18:3], result_handle[50:19], is_queued[51], zeros above
    output logic [trqm_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind[0]
    output logic                            m_tuser
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int MW = (ID_BITS > trqm_pkg::TASK_ID_W) ? ID_BITS : trqm_pkg::TASK_ID_W;
    localparam int DW = trqm_pkg::HANDLE_W + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
    localparam logic [MW-1:0] ID_MASK   = {MW{1'b1}} >> (MW - ID_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_ADD_WR,
        S_SCHED_WR,
        S_DISP_RD,
        S_DISP_DO,
        S_RMH_RD,
        S_RMH_DO,
        S_WALK_RD,
        S_WALK_CMP,
        S_FIX_RD,
        S_FIX_WR,
        S_RESP
    } state_t;

    // Control state.
    state_t                   state_reg, state_next;
    trqm_pkg::slot_state_t    slot_st_reg [SLOTS];
    trqm_pkg::slot_state_t    slot_st_next [SLOTS];
    logic [SW-1:0]            head_reg, head_next;
    logic [SW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     run_valid_reg, run_valid_next;
    logic [SW-1:0]            run_slot_reg, run_slot_next;
    logic [ID_BITS-1:0]       next_id_reg, next_id_next;
    trqm_pkg::match_mode_t    mode_reg, mode_next;
    logic [SW-1:0]            issue_reg, issue_next;
    logic [SW-1:0]            cmp_idx_reg, cmp_idx_next;
    logic                     cmp_valid_reg, cmp_valid_next;
    logic [SW-1:0]            slot_reg, slot_next;
    logic [SW-1:0]            prev_reg, prev_next;
    logic [CW-1:0]            walk_n_reg, walk_n_next;
    logic                     m_valid_reg, m_valid_next;

    // Latched request and pending result.
    logic [trqm_pkg::ACTION_W-1:0]  act_reg, act_next;
    logic [MW-1:0]                  key_reg, key_next;
    logic                           kind_reg, kind_next;
    logic [trqm_pkg::HANDLE_W-1:0]  handle_reg, handle_next;
    logic [trqm_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [trqm_pkg::TASK_ID_W-1:0] res_id_reg, res_id_next;
    logic                           res_kind_reg, res_kind_next;
    logic [trqm_pkg::HANDLE_W-1:0]  res_handle_reg, res_handle_next;
    logic                           res_queued_reg, res_queued_next;
    logic [trqm_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                           m_user_reg, m_user_next;

    // Memory ports.
    logic               id_we;
    logic [SW-1:0]      id_raddr;
    logic [ID_BITS-1:0] id_rdata;
    logic               dat_we;
    logic [DW-1:0]      dat_rdata;
    logic               lnk_we;
    logic [SW-1:0]      lnk_waddr, lnk_wdata, lnk_raddr, lnk_rdata;

    // Decoded input fields.
    logic [trqm_pkg::ACTION_W-1:0]  in_action;
    logic [trqm_pkg::TASK_ID_W-1:0] in_task_id;
    logic [trqm_pkg::HANDLE_W-1:0]  in_handle;
    logic                           accept;
    logic                           qualify;
    logic                           hit;
    trqm_pkg::slot_state_t          cmp_st;

    assign in_action  = s_tdata[2:0];
    assign in_task_id = s_tdata[18:3];
    assign in_handle  = s_tdata[50:19];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;

    // Memory address and write selection.
    assign id_we     = (state_reg == S_ADD_WR);
    assign dat_we    = (state_reg == S_ADD_WR);
    assign id_raddr  = (state_reg == S_SEARCH) ? issue_reg : head_reg;
    assign lnk_we    = (state_reg == S_SCHED_WR && count_reg != '0) || (state_reg == S_FIX_WR);
    assign lnk_waddr = (state_reg == S_FIX_WR) ? prev_reg : tail_reg;
    assign lnk_wdata = (state_reg == S_FIX_WR) ? lnk_rdata : slot_reg;

    always_comb
    begin
        unique case (state_reg)
            S_WALK_RD: lnk_raddr = prev_reg;
            S_FIX_RD:  lnk_raddr = slot_reg;
            default:   lnk_raddr = head_reg;
        endcase
    end

    trqm_ram #(.WIDTH(ID_BITS), .DEPTH(SLOTS)) u_id_ram (
        .clk   (clk),
        .we    (id_we),
        .waddr (slot_reg),
        .wdata (next_id_reg),
        .raddr (id_raddr),
        .rdata (id_rdata)
    );

    trqm_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_dat_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (slot_reg),
        .wdata ({kind_reg, handle_reg}),
        .raddr (head_reg),
        .rdata (dat_rdata)
    );

    trqm_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_link_ram (
        .clk   (clk),
        .we    (lnk_we),
        .waddr (lnk_waddr),
        .wdata (lnk_wdata),
        .raddr (lnk_raddr),
        .rdata (lnk_rdata)
    );

    // Slot test for the table walk: status from the flops, id from the memory.
    always_comb
    begin
        cmp_st = slot_st_reg[cmp_idx_reg];
        case (mode_reg)
            trqm_pkg::MATCH_FREE:    qualify = (cmp_st == trqm_pkg::SLOT_FREE);
            trqm_pkg::MATCH_STOPPED: qualify = (cmp_st == trqm_pkg::SLOT_STOPPED) &&
                                               (MW'(id_rdata) == key_reg);
            default:                 qualify = (cmp_st == trqm_pkg::SLOT_STOPPED ||
                                                cmp_st == trqm_pkg::SLOT_SCHED) &&
                                               (MW'(id_rdata) == key_reg);
        endcase
        hit = cmp_valid_reg && qualify;
    end

    // Next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        slot_st_next    = slot_st_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        run_valid_next  = run_valid_reg;
        run_slot_next   = run_slot_reg;
        next_id_next    = next_id_reg;
        mode_next       = mode_reg;
        issue_next      = issue_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        slot_next       = slot_reg;
        prev_next       = prev_reg;
        walk_n_next     = walk_n_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        kind_next       = kind_reg;
        handle_next     = handle_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_kind_next   = res_kind_reg;
        res_handle_next = res_handle_reg;
        res_queued_next = res_queued_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = in_action;
                    key_next        = MW'(in_task_id) & ID_MASK;
                    kind_next       = s_tuser;
                    handle_next     = in_handle;
                    res_status_next = trqm_pkg::STS_OK;
                    res_id_next     = '0;
                    res_kind_next   = 1'b0;
                    res_handle_next = '0;
                    res_queued_next = 1'b0;
                    issue_next      = '0;
                    cmp_valid_next  = 1'b0;
                    state_next      = S_RESP;
                    case (in_action) inside
                        trqm_pkg::ACT_ADD:
                        begin
                            if (in_handle == '0)
                            begin
                                res_status_next = trqm_pkg::STS_NULL;
                            end
                            else
                            begin
                                mode_next  = trqm_pkg::MATCH_FREE;
                                state_next = S_SEARCH;
                            end
                        end
                        trqm_pkg::ACT_SCHEDULE:
                        begin
                            mode_next  = trqm_pkg::MATCH_STOPPED;
                            state_next = S_SEARCH;
                        end
                        trqm_pkg::ACT_QUERY, trqm_pkg::ACT_REMOVE:
                        begin
                            mode_next  = trqm_pkg::MATCH_LIVE;
                            state_next = S_SEARCH;
                        end
                        trqm_pkg::ACT_DISPATCH:
                        begin
                            if (run_valid_reg)
                            begin
                                res_status_next = trqm_pkg::STS_RUNNING;
                            end
                            else if (count_reg == '0)
                            begin
                                res_status_next = trqm_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                state_next = S_DISP_RD;
                            end
                        end
                        trqm_pkg::ACT_FINISH:
                        begin
                            if (!run_valid_reg)
                            begin
                                res_status_next = trqm_pkg::STS_RUNNING;
                            end
                            else
                            begin
                                slot_st_next[run_slot_reg] = trqm_pkg::SLOT_STOPPED;
                                run_valid_next             = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Walk the table: issue one id read a cycle, test the one issued before.
            S_SEARCH:
            begin
                if (hit)
                begin
                    slot_next  = cmp_idx_reg;
                    state_next = S_RESP;
                    case (act_reg)
                        trqm_pkg::ACT_ADD:      state_next = S_ADD_WR;
                        trqm_pkg::ACT_SCHEDULE: state_next = S_SCHED_WR;
                        trqm_pkg::ACT_QUERY:
                            res_queued_next = (cmp_st == trqm_pkg::SLOT_SCHED);
                        default:
                        begin
                            slot_st_next[cmp_idx_reg] = trqm_pkg::SLOT_FREE;
                            if (cmp_st == trqm_pkg::SLOT_SCHED && count_reg != '0)
                            begin
                                if (cmp_idx_reg == head_reg)
                                begin
                                    state_next = S_RMH_RD;
                                end
                                else
                                begin
                                    prev_next   = head_reg;
                                    walk_n_next = CW'(1);
                                    state_next  = S_WALK_RD;
                                end
                            end
                        end
                    endcase
                end
                else if (cmp_valid_reg && cmp_idx_reg == LAST_SLOT)
                begin
                    res_status_next = (act_reg == trqm_pkg::ACT_ADD) ?
                                      trqm_pkg::STS_FULL : trqm_pkg::STS_NOT_FOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    cmp_idx_next   = issue_reg;
                    cmp_valid_next = 1'b1;
                    if (issue_reg != LAST_SLOT)
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end

            S_ADD_WR:
            begin
                slot_st_next[slot_reg] = trqm_pkg::SLOT_STOPPED;
                res_id_next            = trqm_pkg::TASK_ID_W'(MW'(next_id_reg));
                next_id_next           = next_id_reg + 1'b1;
                state_next             = S_RESP;
            end

            // Append to the queue tail; when the queue is not empty, the old tail's link is written in this cycle.
            S_SCHED_WR:
            begin
                slot_st_next[slot_reg] = trqm_pkg::SLOT_SCHED;
                if (count_reg == '0)
                begin
                    head_next = slot_reg;
                end
                tail_next  = slot_reg;
                count_next = count_reg + 1'b1;
                state_next = S_RESP;
            end

            S_DISP_RD:
            begin
                state_next = S_DISP_DO;
            end

            S_DISP_DO:
            begin
                if (count_reg > CW'(1))
                begin
                    head_next = lnk_rdata;
                end
                count_next             = count_reg - 1'b1;
                slot_st_next[head_reg] = trqm_pkg::SLOT_RUN;
                run_valid_next         = 1'b1;
                run_slot_next          = head_reg;
                res_id_next            = trqm_pkg::TASK_ID_W'(MW'(id_rdata));
                res_kind_next          = dat_rdata[DW-1];
                res_handle_next        = dat_rdata[trqm_pkg::HANDLE_W-1:0];
                state_next             = S_RESP;
            end

            S_RMH_RD:
            begin
                state_next = S_RMH_DO;
            end

            S_RMH_DO:
            begin
                if (count_reg > CW'(1))
                begin
                    head_next = lnk_rdata;
                end
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end

            // Follow the links from the head to find the predecessor.
            S_WALK_RD:
            begin
                state_next = (walk_n_reg < count_reg) ? S_WALK_CMP : S_RESP;
            end

            S_WALK_CMP:
            begin
                if (lnk_rdata == slot_reg)
                begin
                    state_next = S_FIX_RD;
                end
                else
                begin
                    prev_next   = lnk_rdata;
                    walk_n_next = walk_n_reg + 1'b1;
                    state_next  = S_WALK_RD;
                end
            end

            S_FIX_RD:
            begin
                state_next = S_FIX_WR;
            end

            // Predecessor now skips the removed slot.
            S_FIX_WR:
            begin
                if (slot_reg == tail_reg)
                begin
                    tail_next = prev_reg;
                end
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, res_queued_reg, res_handle_reg, res_id_reg,
                                    res_status_reg};
                    m_user_next  = res_kind_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_st_reg[i] <= trqm_pkg::SLOT_FREE;
            end
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            next_id_reg   <= '0;
            mode_reg      <= trqm_pkg::MATCH_FREE;
            issue_reg     <= '0;
            cmp_idx_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            slot_reg      <= '0;
            prev_reg      <= '0;
            walk_n_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_st_reg   <= slot_st_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            next_id_reg   <= next_id_next;
            mode_reg      <= mode_next;
            issue_reg     <= issue_next;
            cmp_idx_reg   <= cmp_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            slot_reg      <= slot_next;
            prev_reg      <= prev_next;
            walk_n_reg    <= walk_n_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        kind_reg       <= kind_next;
        handle_reg     <= handle_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_queued_reg <= res_queued_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // The running slot always holds a task marked as running.
    a_run_slot: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> (slot_st_reg[run_slot_reg] == trqm_pkg::SLOT_RUN))
        else $error("running slot not marked running");

    // The queue never holds more tasks than there are slots.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
        else $error("queue count beyond table size");

    // One transfer is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while busy");

endmodule
